@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros included by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

@@ hw/rtl/oaht_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants of the open addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;
  localparam int Capacity = 1024;
  localparam int IdxW     = $clog2(Capacity);
  localparam int SizeW    = 11;
  localparam int KeyW     = 64;
  localparam int HashW    = 32;
  localparam int DataW    = 32;
  localparam int DelW     = 11;
  // used flag, key, hash, data, data-present flag
  localparam int EntW     = 1 + KeyW + HashW + DataW + 1;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DELETED   = 3'd3,
    ST_FULL      = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  localparam logic [0:0] REG_TABLE_SIZE   = 1'b0;
  localparam logic [0:0] REG_COMPARE_KEYS = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request, start modulo
    logic mod_step;   // one restoring-division step
    logic probe_rd;   // issue read at current probe index
    logic advance;    // move to next probe index
    logic wr_entry;   // write slot entry
    logic clr_used;   // clear one slot entry (sweep)
    logic sweep_step; // advance clear pointer
    logic sweep_init;
    logic finish;     // register result
    logic full;       // result is table full
    logic cleared;    // result is cleared
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic    mod_done;
    logic    slot_used;
    logic    match;
    logic    last_probe;
    logic    sweep_done;
    op_t     op;
  } sts_t;
endpackage

@@ hw/rtl/oaht_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module oaht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem_r [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule

@@ hw/rtl/oaht_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_datapath
// Request registers, serial modulo, probe index walk, slot store and result.
// ----------------------------------------------------------------------------
module oaht_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  oaht_pkg::ctl_t                ctl,
  output oaht_pkg::sts_t                sts,
  input  logic [1:0]                    in_operation,
  input  logic [63:0]                   in_key,
  input  logic [31:0]                   in_key_hash,
  input  logic [31:0]                   in_data_value,
  input  logic [oaht_pkg::SizeW-1:0]    table_size,
  input  logic                          compare_keys,
  output logic [2:0]                    out_status,
  output logic [9:0]                    out_slot_index,
  output logic [31:0]                   out_data_out,
  output logic                          out_data_present,
  output logic [10:0]                   out_deleted_count
);
  import oaht_pkg::*;

  localparam int CntW = $clog2(HashW + 1);

  op_t              op_r;
  logic [KeyW-1:0]  key_r;
  logic [HashW-1:0] hash_r;
  logic [DataW-1:0] data_r;
  logic [SizeW-1:0] size_r;
  logic             cmp_r;
  logic [HashW-1:0] quo_r;
  logic [SizeW:0]   rem_r, rem_nxt;
  logic [CntW-1:0]  bit_cnt_r;
  logic [SizeW-1:0] ndx_r, step_r, probes_r;
  logic [SizeW+1:0] ndx_sum, ndx_sub1, ndx_sub2;
  logic [SizeW-1:0] ndx_adv;
  logic [DelW-1:0]  del_r, del_nxt;
  logic [IdxW-1:0]  sweep_r;
  logic [IdxW-1:0]  ram_addr;
  logic [SizeW-1:0] eff_size;
  logic [EntW-1:0]  rd_ent, wr_ent, ram_wdata;
  logic             s_used;
  logic [KeyW-1:0]  s_key;
  logic [HashW-1:0] s_hash;
  logic [DataW-1:0] s_data;
  logic             s_has;
  logic             hit_q;
  logic             we;
  status_t          status_nxt;
  logic [9:0]       slot_nxt;
  logic [DataW-1:0] dout_nxt;
  logic             present_nxt;

  always_comb begin
    eff_size = table_size;
    if (table_size == '0) eff_size = SizeW'(1);
    else if (table_size > SizeW'(Capacity)) eff_size = SizeW'(Capacity);
  end

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_nxt = {rem_r[SizeW-1:0], quo_r[HashW-1]};
    if (rem_nxt >= {1'b0, size_r}) rem_nxt = rem_nxt - {1'b0, size_r};
  end

  // step stays below twice the size, so the sum is below three times the size
  assign ndx_sum  = {2'b00, ndx_r} + {2'b00, step_r};
  assign ndx_sub1 = ndx_sum - {2'b00, size_r};
  assign ndx_sub2 = ndx_sum - {1'b0, size_r, 1'b0};

  always_comb begin
    ndx_adv = ndx_sum[SizeW-1:0];
    if (ndx_sum >= {1'b0, size_r, 1'b0}) ndx_adv = ndx_sub2[SizeW-1:0];
    else if (ndx_sum >= {2'b00, size_r}) ndx_adv = ndx_sub1[SizeW-1:0];
  end

  assign {s_used, s_key, s_hash, s_data, s_has} = rd_ent;
  assign hit_q = (s_hash == hash_r) && (!cmp_r || s_key == key_r);

  always_comb begin
    wr_ent = rd_ent;
    if (op_r == OP_INSERT) begin
      if (s_used && hit_q) wr_ent = {1'b1, s_key, s_hash, data_r, 1'b1};
      else wr_ent = {1'b1, key_r, hash_r, data_r, 1'b1};
    end else if (op_r == OP_DELETE) begin
      wr_ent = {1'b1, s_key, s_hash, s_data, 1'b0};
    end
  end

  // sweep owns the RAM port while it runs
  assign we        = ctl.wr_entry | ctl.clr_used;
  assign ram_addr  = ctl.clr_used ? sweep_r : ndx_r[IdxW-1:0];
  assign ram_wdata = ctl.clr_used ? '0 : wr_ent;

  oaht_ram #(.Width(EntW), .Depth(Capacity)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rd_ent)
  );

  assign sts.mod_done   = (bit_cnt_r == '0);
  assign sts.slot_used  = s_used;
  assign sts.match      = hit_q;
  assign sts.last_probe = (probes_r == size_r - SizeW'(1));
  assign sts.sweep_done = (sweep_r == IdxW'(Capacity - 1));
  assign sts.op         = op_r;

  always_comb begin
    status_nxt  = ST_FULL;
    slot_nxt    = ndx_r[9:0];
    dout_nxt    = '0;
    present_nxt = 1'b0;
    del_nxt     = del_r;
    if (ctl.cleared) begin
      status_nxt = ST_CLEARED;
      slot_nxt   = '0;
      del_nxt    = '0;
    end else if (ctl.full) begin
      status_nxt = ST_FULL;
      slot_nxt   = '0;
    end else begin
      unique case (op_r)
        OP_LOOKUP: begin
          if (!s_used) status_nxt = ST_NOT_FOUND;
          else begin
            status_nxt  = ST_FOUND;
            present_nxt = s_has;
            dout_nxt    = s_has ? s_data : '0;
          end
        end
        OP_INSERT: begin
          status_nxt  = s_used ? ST_FOUND : ST_INSERTED;
          dout_nxt    = data_r;
          present_nxt = 1'b1;
        end
        OP_DELETE: begin
          if (s_used && s_has) begin
            status_nxt = ST_DELETED;
            dout_nxt   = s_data;
            if (del_r != '1) del_nxt = del_r + DelW'(1);
          end else status_nxt = ST_NOT_FOUND;
        end
        default: status_nxt = ST_CLEARED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      del_r     <= '0;
      bit_cnt_r <= '0;
      sweep_r   <= '0;
      out_status <= ST_FULL;
      out_slot_index <= '0;
      out_data_out <= '0;
      out_data_present <= 1'b0;
      out_deleted_count <= '0;
    end else begin
      if (ctl.load) begin
        op_r      <= op_t'(in_operation);
        key_r     <= in_key;
        hash_r    <= in_key_hash;
        quo_r     <= in_key_hash;
        data_r    <= in_data_value;
        size_r    <= eff_size;
        cmp_r     <= compare_keys;
        rem_r     <= '0;
        bit_cnt_r <= CntW'(HashW);
        step_r    <= SizeW'(1);
        probes_r  <= '0;
      end
      if (ctl.mod_step) begin
        rem_r     <= rem_nxt;
        quo_r     <= {quo_r[HashW-2:0], 1'b0};
        bit_cnt_r <= bit_cnt_r - CntW'(1);
        if (bit_cnt_r == CntW'(1)) ndx_r <= rem_nxt[SizeW-1:0];
      end
      if (ctl.advance) begin
        ndx_r    <= ndx_adv;
        step_r   <= step_r + SizeW'(2);
        probes_r <= probes_r + SizeW'(1);
      end
      if (ctl.sweep_init) begin
        sweep_r <= '0;
        del_r   <= '0;
      end else begin
        if (ctl.sweep_step) sweep_r <= sweep_r + IdxW'(1);
        if (ctl.finish) del_r <= del_nxt;
      end
      if (ctl.finish) begin
        out_status        <= status_nxt;
        out_slot_index    <= slot_nxt;
        out_data_out      <= dout_nxt;
        out_data_present  <= present_nxt;
        out_deleted_count <= del_nxt;
      end
    end
  end
endmodule

@@ hw/rtl/oaht_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_ctrl
// Request sequencer: modulo, probe loop, update, slot clear sweep.
// ----------------------------------------------------------------------------
module oaht_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           out_valid,
  output oaht_pkg::ctl_t ctl,
  input  oaht_pkg::sts_t sts
);
  import oaht_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_READ, S_CHECK, S_SWEEP, S_DONE, S_INIT
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_nxt;

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.op == OP_CLEAR) begin
          ctl.sweep_init = 1'b1;
          state_nxt = S_SWEEP;
        end else if (sts.mod_done) state_nxt = S_READ;
        else ctl.mod_step = 1'b1;
      end
      S_READ: state_nxt = S_CHECK; // RAM read in flight
      S_CHECK: begin
        if (!sts.slot_used || sts.match) begin
          ctl.finish = 1'b1;
          valid_nxt  = 1'b1;
          state_nxt  = S_DONE;
          if (sts.op == OP_INSERT) ctl.wr_entry = 1'b1;
          if (sts.op == OP_DELETE && sts.slot_used) ctl.wr_entry = 1'b1;
        end else if (sts.last_probe) begin
          ctl.finish = 1'b1;
          ctl.full   = 1'b1;
          valid_nxt  = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          ctl.advance = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_SWEEP: begin
        ctl.clr_used   = 1'b1;
        ctl.sweep_step = 1'b1;
        if (sts.sweep_done) begin
          ctl.finish  = 1'b1;
          ctl.cleared = 1'b1;
          valid_nxt   = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      // empty the slot store after reset, no result
      S_INIT: begin
        ctl.clr_used   = 1'b1;
        ctl.sweep_step = 1'b1;
        if (sts.sweep_done) state_nxt = S_IDLE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= valid_nxt;
    end
  end
endmodule

@@ hw/rtl/open_addressing_hash_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table_core
// Hash table with quadratic probing over a single-port slot RAM.
// ----------------------------------------------------------------------------
// A request runs the serial modulo, then each probe issues a slot RAM read and
// checks the registered read data; clear skips the probe loop and sweeps one
// slot entry per cycle. One request at a time: the next is taken only after
// busy falls; out_valid pulses once.
// Reset: a sweep of all 1024 slot entries with busy high, deletion count zero,
// table_size 31, compare_keys 1.
module open_addressing_hash_table_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_key,
  input  logic [31:0] in_key_hash,
  input  logic [31:0] in_data_value,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [9:0]  out_slot_index,
  output logic [31:0] out_data_out,
  output logic        out_data_present,
  output logic [10:0] out_deleted_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import oaht_pkg::*;

  logic [SizeW-1:0] cfg_table_size_r;
  logic             cfg_compare_keys_r;
  ctl_t ctl;
  sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_table_size_r   <= SizeW'(31);
      cfg_compare_keys_r <= 1'b1;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_TABLE_SIZE) cfg_table_size_r <= pwdata[SizeW-1:0];
      else cfg_compare_keys_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TABLE_SIZE) prdata[SizeW-1:0] = cfg_table_size_r;
    else prdata[0] = cfg_compare_keys_r;
  end

  oaht_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .ctl(ctl), .sts(sts)
  );

  oaht_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_operation(in_operation), .in_key(in_key), .in_key_hash(in_key_hash),
    .in_data_value(in_data_value), .table_size(cfg_table_size_r),
    .compare_keys(cfg_compare_keys_r), .out_status(out_status),
    .out_slot_index(out_slot_index), .out_data_out(out_data_out),
    .out_data_present(out_data_present), .out_deleted_count(out_deleted_count)
  );
endmodule

@@ hw/rtl/oaht_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_checker
// Port-level checks of the hash table core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module oaht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [10:0] out_deleted_count
);
  import oaht_pkg::*;

  `CHK_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `CHK_NEXT(a_valid_pulse, clk, rst_n, out_valid, !out_valid)
  `CHK_IMPL(a_status_range, clk, rst_n, out_valid, out_status <= ST_CLEARED)
  `CHK_IMPL(a_clear_count, clk, rst_n, out_valid && out_status == ST_CLEARED,
            out_deleted_count == 11'd0)
endmodule

bind open_addressing_hash_table_core oaht_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_deleted_count(out_deleted_count)
);
